### rtl/bhc_pkg.sv
package bhc_pkg;

   localparam int unsigned HEADER_BYTES = 24;
   localparam int unsigned CRC_BYTES    = 20;
   localparam int unsigned COUNT_W      = 5;

   localparam logic [31:0] CRC_POLY_REFLECTED = 32'h82F6_3B78;
   localparam logic [33:0] RAW_SLACK          = 34'd1024;

   // Header byte positions.
   localparam logic [COUNT_W-1:0] POS_FLAGS     = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] POS_CODEC     = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] POS_CRC_FIRST = COUNT_W'(CRC_BYTES);
   localparam logic [COUNT_W-1:0] POS_LAST      = COUNT_W'(HEADER_BYTES - 1);

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
   localparam logic [1:0] STATUS_CORRUPT   = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_BLOCK_MAGIC = 2'd0;
   localparam logic [1:0] REG_STORED_MASK = 2'd1;
   localparam logic [1:0] REG_MAX_RAW     = 2'd2;

   localparam logic [15:0] MAGIC_RESET   = 16'h0000;
   localparam logic [7:0]  MASK_RESET    = 8'h01;
   localparam logic [31:0] MAX_RAW_RESET = 32'd268435456;

   typedef struct packed {
      logic [15:0] block_magic_value;
      logic [7:0]  stored_flag_mask;
      logic [31:0] max_raw_block_size;
   } bhc_cfg_type;

   typedef struct packed {
      logic [63:0] stream_offset;
      logic [31:0] raw_len;
      logic [31:0] stored_len;
      logic [7:0]  codec_number;
      logic [7:0]  block_flags;
      logic [1:0]  status;
   } bhc_result_type;

   localparam int unsigned RESULT_W = $bits(bhc_result_type);
   localparam int unsigned RSP_W    = ((RESULT_W + 7) / 8) * 8;

   // Reflected CRC-32C over one byte, one bit per step.
   function automatic logic [31:0] bhc_crc_byte(input logic [31:0] crc,
                                                input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFLECTED;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/bhc_csr.sv
module bhc_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output bhc_pkg::bhc_cfg_type cfg
);
   import bhc_pkg::*;

   logic [15:0] magic_ff, magic_in;
   logic [7:0]  mask_ff, mask_in;
   logic [31:0] max_raw_ff, max_raw_in;
   logic        write_en;
   logic [1:0]  reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_index  = csr_paddr[3:2];

   always_comb begin
      magic_in   = magic_ff;
      mask_in    = mask_ff;
      max_raw_in = max_raw_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_BLOCK_MAGIC: magic_in   = csr_pwdata[15:0];
            REG_STORED_MASK: mask_in    = csr_pwdata[7:0];
            REG_MAX_RAW:     max_raw_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_BLOCK_MAGIC: csr_prdata = {16'd0, magic_ff};
         REG_STORED_MASK: csr_prdata = {24'd0, mask_ff};
         REG_MAX_RAW:     csr_prdata = max_raw_ff;
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= MAGIC_RESET;
         mask_ff    <= MASK_RESET;
         max_raw_ff <= MAX_RAW_RESET;
      end else begin
         magic_ff   <= magic_in;
         mask_ff    <= mask_in;
         max_raw_ff <= max_raw_in;
      end
   end

   assign cfg.block_magic_value  = magic_ff;
   assign cfg.stored_flag_mask   = mask_ff;
   assign cfg.max_raw_block_size = max_raw_ff;

endmodule

### rtl/bhc_capture.sv
module bhc_capture (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   beat_valid,
   input  logic [7:0]             data_byte,
   input  logic                   end_of_buffer,
   input  bhc_pkg::bhc_cfg_type   cfg,
   output logic                   result_load,
   output bhc_pkg::bhc_result_type result
);
   import bhc_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [31:0]        crc_ff, crc_in;
   logic               done_ff, done_in;
   logic [15:0]        magic_ff, magic_in;
   logic [7:0]         flags_ff, flags_in;
   logic [7:0]         codec_ff, codec_in;
   logic [31:0]        stored_ff, stored_in;
   logic [31:0]        raw_ff, raw_in;
   logic [63:0]        offset_ff, offset_in;
   logic [23:0]        rcrc_ff, rcrc_in;
   logic               fields_bad_ff, fields_bad_in;
   logic [2:0]         off_idx;
   logic [33:0]        raw_limit;
   logic [64:0]        end_offset;
   logic               crc_bad;

   // Field checks run every cycle on the held fields. They are final from
   // the beat after byte 19 on, well before the last header byte arrives.
   always_comb begin
      raw_limit  = {2'd0, raw_ff} + {5'd0, raw_ff[31:3]} + RAW_SLACK;
      end_offset = {1'b0, offset_ff} + {33'd0, raw_ff};
      fields_bad_in = (magic_ff != cfg.block_magic_value)
         || (((flags_ff & cfg.stored_flag_mask) != 8'd0) && (stored_ff != raw_ff))
         || (raw_ff == 32'd0) || (raw_ff > cfg.max_raw_block_size)
         || ({2'd0, stored_ff} > raw_limit)
         || end_offset[64];
   end

   assign off_idx = count_ff[2:0] - 3'd4;
   assign crc_bad = (~crc_ff) != {data_byte, rcrc_ff};

   always_comb begin
      count_in    = count_ff;
      crc_in      = crc_ff;
      done_in     = done_ff;
      magic_in    = magic_ff;
      flags_in    = flags_ff;
      codec_in    = codec_ff;
      stored_in   = stored_ff;
      raw_in      = raw_ff;
      offset_in   = offset_ff;
      rcrc_in     = rcrc_ff;
      result_load = 1'b0;
      result      = '0;
      if (beat_valid) begin
         if (done_ff) begin
            if (end_of_buffer) begin
               count_in = '0;
               crc_in   = '1;
               done_in  = 1'b0;
            end
         end else begin
            if (count_ff < POS_CRC_FIRST) begin
               crc_in = bhc_crc_byte(crc_ff, data_byte);
            end
            case (count_ff) inside
               [5'd0:5'd1]:   magic_in[{count_ff[0], 3'b000} +: 8] = data_byte;
               POS_FLAGS:     flags_in = data_byte;
               POS_CODEC:     codec_in = data_byte;
               [5'd4:5'd7]:   stored_in[{count_ff[1:0], 3'b000} +: 8] = data_byte;
               [5'd8:5'd11]:  raw_in[{count_ff[1:0], 3'b000} +: 8] = data_byte;
               [5'd12:5'd19]: offset_in[{off_idx, 3'b000} +: 8] = data_byte;
               [5'd20:5'd22]: rcrc_in[{count_ff[1:0], 3'b000} +: 8] = data_byte;
               default: ;
            endcase
            if (count_ff == POS_LAST) begin
               result_load = 1'b1;
               if (fields_bad_ff || crc_bad) begin
                  result.status = STATUS_CORRUPT;
               end else begin
                  result.status        = STATUS_OK;
                  result.block_flags   = flags_ff;
                  result.codec_number  = codec_ff;
                  result.stored_len    = stored_ff;
                  result.raw_len       = raw_ff;
                  result.stream_offset = offset_ff;
               end
               if (end_of_buffer) begin
                  count_in = '0;
                  crc_in   = '1;
               end else begin
                  done_in = 1'b1;
               end
            end else if (end_of_buffer) begin
               result_load   = 1'b1;
               result.status = STATUS_TRUNCATED;
               count_in      = '0;
               crc_in        = '1;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= '1;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      magic_ff      <= magic_in;
      flags_ff      <= flags_in;
      codec_ff      <= codec_in;
      stored_ff     <= stored_in;
      raw_ff        <= raw_in;
      offset_ff     <= offset_in;
      rcrc_ff       <= rcrc_in;
      fields_bad_ff <= fields_bad_in;
   end

endmodule

### rtl/block_header_checker.sv
// Checks the 24-byte header of a compressed block, one byte beat per clock
// cycle, and returns one result beat per header: ok with the decoded fields,
// corrupt (bad magic, CRC-32C, sizes or offset) with zero fields, or
// truncated when tlast arrives before the 24th byte. Bytes after a full
// header are dropped up to and including the tlast beat, and the next header
// starts after it. The CRC byte update and the field capture sit between
// the request handshake and the result register, so the request side stalls
// only while a result beat is held unaccepted. The result beat is registered
// and appears in the cycle after its last header byte is taken.
// Configure the registers only while no header is in progress.
module block_header_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tlast,   // end_of_buffer
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], block_flags[9:2], codec_number[17:10], stored_len[49:18],
   // raw_len[81:50], stream_offset[145:82], zero fill above
   output logic [151:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import bhc_pkg::*;

   bhc_cfg_type    cfg;
   bhc_result_type result;
   logic           result_load;
   logic           req_beat;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   bhc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bhc_capture u_capture (
      .clock         (clock),
      .reset         (reset),
      .beat_valid    (req_beat),
      .data_byte     (req_tdata),
      .end_of_buffer (req_tlast),
      .cfg           (cfg),
      .result_load   (result_load),
      .result        (result)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'(result);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
